[hw/rtl/linear_congruential_rng_defines.svh]
// Assertion macros for the linear congruential generator.
`ifndef LINEAR_CONGRUENTIAL_RNG_DEFINES_SVH
`define LINEAR_CONGRUENTIAL_RNG_DEFINES_SVH

`ifndef SYNTH
`define LCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("LCG assertion failed");
`define LCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LCG assertion failed");
`else
`define LCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/lcg_pkg.sv]
// Package with widths, reset values and register codes of the generator.
`timescale 1ns / 1ps
package lcg_pkg;
    localparam int VAL_W   = 31;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int PROD_W  = 2 * VAL_W;

    localparam logic [VAL_W-1:0] RESET_MODULUS    = 31'd2147483647;
    localparam logic [VAL_W-1:0] RESET_MULTIPLIER = 31'd16807;
    localparam logic [VAL_W-1:0] RESET_INCREMENT  = 31'd0;
    localparam logic [VAL_W-1:0] RESET_SEED       = 31'd9035768;

    typedef enum logic [1:0] {
        REG_MODULUS    = 2'd0,
        REG_MULTIPLIER = 2'd1,
        REG_INCREMENT  = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg;

    localparam logic ACTION_NEXT = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;
endpackage

[hw/rtl/linear_congruential_rng.sv]
// Linear congruential generator with a bit-serial modulo reduction.
// A next item is accepted in idle; the multiply state forms the product, the add state
// adds the increment, restoring division reduces all 62 product bits, and write-back
// stores the remainder to seed and output once the output register is free (it stalls).
// A load item only replaces the seed. Input is not ready until write-back ends.
// Synchronous active-low reset restores the default registers and the seed.
`timescale 1ns / 1ps
`include "linear_congruential_rng_defines.svh"
module linear_congruential_rng (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lcg_pkg::DATA_W-1:0]  s_axis_tdata,   // [30:0] seed_value
    input  logic                        s_axis_tuser,   // [0] action
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lcg_pkg::DATA_W-1:0]  m_axis_tdata,   // [30:0] random_value
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcg_pkg::ADDR_W-1:0]  paddr,
    input  logic [lcg_pkg::DATA_W-1:0]  pwdata,
    output logic [lcg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    localparam int CNT_W = $clog2(lcg_pkg::PROD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                         r_state;
    logic [lcg_pkg::VAL_W-1:0]      r_mod;
    logic [lcg_pkg::VAL_W-1:0]      r_mult;
    logic [lcg_pkg::VAL_W-1:0]      r_inc;
    logic [lcg_pkg::VAL_W-1:0]      r_seed;
    logic [lcg_pkg::PROD_W-1:0]     r_div;
    logic [lcg_pkg::VAL_W-1:0]      r_rem;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_out_valid;
    logic [lcg_pkg::VAL_W-1:0]      r_out_data;

    logic                           w_in_acc;
    logic                           w_acc_next;
    logic                           w_acc_load;
    logic [lcg_pkg::VAL_W-1:0]      w_in_seed;
    logic                           w_cfg_wr;
    lcg_pkg::t_reg                  w_reg;
    logic [lcg_pkg::PROD_W-1:0]     w_prod;
    logic [lcg_pkg::VAL_W:0]        w_trial;
    logic [lcg_pkg::VAL_W-1:0]      n_rem;
    logic [lcg_pkg::VAL_W-1:0]      w_result;
    logic                           w_out_free;
    logic                           w_done_fire;
    logic                           w_out_is_seed;

    assign pready        = 1'b1;
    assign w_reg         = lcg_pkg::t_reg'(paddr[3:2]);
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_acc_next    = w_in_acc && (s_axis_tuser == lcg_pkg::ACTION_NEXT);
    assign w_acc_load    = w_in_acc && (s_axis_tuser == lcg_pkg::ACTION_LOAD);
    assign w_in_seed     = s_axis_tdata[lcg_pkg::VAL_W-1:0];
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_done_fire   = (r_state == ST_DONE) && w_out_free;
    assign w_out_is_seed = r_out_valid && (r_out_data == r_seed);

    assign w_prod   = lcg_pkg::PROD_W'(r_mult) * lcg_pkg::PROD_W'(r_seed);
    assign w_trial  = {r_rem, r_div[lcg_pkg::PROD_W-1]};
    assign n_rem    = (w_trial >= {1'b0, r_mod}) ? lcg_pkg::VAL_W'(w_trial - {1'b0, r_mod})
                                                 : w_trial[lcg_pkg::VAL_W-1:0];
    assign w_result = (r_mod == '0) ? '0 : r_rem;

    always_comb begin
        unique case (w_reg)
            lcg_pkg::REG_MODULUS:    prdata = {1'b0, r_mod};
            lcg_pkg::REG_MULTIPLIER: prdata = {1'b0, r_mult};
            lcg_pkg::REG_INCREMENT:  prdata = {1'b0, r_inc};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= lcg_pkg::RESET_MODULUS;
            r_mult <= lcg_pkg::RESET_MULTIPLIER;
            r_inc  <= lcg_pkg::RESET_INCREMENT;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                lcg_pkg::REG_MODULUS:    r_mod  <= pwdata[lcg_pkg::VAL_W-1:0];
                lcg_pkg::REG_MULTIPLIER: r_mult <= pwdata[lcg_pkg::VAL_W-1:0];
                lcg_pkg::REG_INCREMENT:  r_inc  <= pwdata[lcg_pkg::VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= lcg_pkg::RESET_SEED;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !w_done_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser == lcg_pkg::ACTION_LOAD) begin
                            r_seed <= w_in_seed;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_div   <= w_prod;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_div   <= r_div + lcg_pkg::PROD_W'(r_inc);
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(lcg_pkg::PROD_W - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_div <= {r_div[lcg_pkg::PROD_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_seed      <= w_result;
                        r_out_data  <= w_result;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `LCG_ASSERT_NEXT(a_next_starts_mul, i_clk, i_rst_n, w_acc_next, r_state == ST_MUL)
    `LCG_ASSERT_NEXT(a_load_sets_seed, i_clk, i_rst_n, w_acc_load, r_seed == $past(w_in_seed))
    `LCG_ASSERT_NEXT(a_result_matches_seed, i_clk, i_rst_n, w_done_fire, w_out_is_seed)
    `LCG_ASSERT_SAME(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready)
endmodule

[tb/sv/linear_congruential_rng_test.sv]
// Self-checking stream and register testbench for the linear congruential generator.
`timescale 1ns / 1ps
module linear_congruential_rng_test;
    typedef struct {
        logic                      action;
        logic [lcg_pkg::VAL_W-1:0] seed;
    } t_lcg_item;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [lcg_pkg::DATA_W-1:0] s_axis_tdata = '0;    // [30:0] seed_value
    logic                       s_axis_tuser = 1'b0;  // [0] action
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [lcg_pkg::DATA_W-1:0] m_axis_tdata;         // [30:0] random_value
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [lcg_pkg::ADDR_W-1:0] paddr = '0;
    logic [lcg_pkg::DATA_W-1:0] pwdata = '0;
    logic [lcg_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    t_lcg_item                 pending_items[$];
    logic [lcg_pkg::VAL_W-1:0] expected_randoms[$];
    logic [lcg_pkg::VAL_W-1:0] gen_modulus = lcg_pkg::RESET_MODULUS;
    logic [lcg_pkg::VAL_W-1:0] gen_multiplier = lcg_pkg::RESET_MULTIPLIER;
    logic [lcg_pkg::VAL_W-1:0] gen_increment = lcg_pkg::RESET_INCREMENT;
    logic [lcg_pkg::VAL_W-1:0] gen_seed = lcg_pkg::RESET_SEED;
    logic                      in_accepted = 1'b0;
    logic                      send_pause = 1'b0;
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    int                        stall_req = 0;
    int                        stall_seen = 0;
    int                        stall_left = 0;
    int                        error_count = 0;

    linear_congruential_rng u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [lcg_pkg::VAL_W-1:0] lcg_advance(
        input logic [lcg_pkg::VAL_W-1:0] seed);
        logic [63:0] full;
        full = 64'(gen_multiplier) * 64'(seed) + 64'(gen_increment);
        if (gen_modulus == '0) begin
            return '0;
        end
        return lcg_pkg::VAL_W'(full % 64'(gen_modulus));
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (in_accepted) begin
                void'(pending_items.pop_front());
            end
            if (s_axis_tvalid && !in_accepted) begin
                s_axis_tvalid <= 1'b1;
            end else if (pending_items.size() != 0 && !send_pause
                         && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_items[0].action;
                s_axis_tdata  <= {1'b0, pending_items[0].seed};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_seen != stall_req) begin
            stall_seen    <= stall_req;
            stall_left    <= 500;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [lcg_pkg::VAL_W-1:0] want;
        in_accepted <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_randoms.size() == 0) begin
                    $error("random_value: unexpected item, expected none, actual %0d",
                           m_axis_tdata[lcg_pkg::VAL_W-1:0]);
                    error_count++;
                end else begin
                    want = expected_randoms.pop_front();
                    if (m_axis_tdata[lcg_pkg::VAL_W-1:0] !== want) begin
                        $error("random_value mismatch: expected %0d, actual %0d",
                               want, m_axis_tdata[lcg_pkg::VAL_W-1:0]);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == lcg_pkg::ACTION_LOAD) begin
                    gen_seed = s_axis_tdata[lcg_pkg::VAL_W-1:0];
                end else begin
                    gen_seed = lcg_advance(gen_seed);
                    expected_randoms.push_back(gen_seed);
                end
            end
        end
    end

    task automatic write_reg(input lcg_pkg::t_reg idx,
                             input logic [lcg_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lcg_pkg::REG_MODULUS:    gen_modulus = value[lcg_pkg::VAL_W-1:0];
            lcg_pkg::REG_MULTIPLIER: gen_multiplier = value[lcg_pkg::VAL_W-1:0];
            lcg_pkg::REG_INCREMENT:  gen_increment = value[lcg_pkg::VAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_item(input logic action, input logic [lcg_pkg::VAL_W-1:0] seed);
        t_lcg_item it;
        it.action = action;
        it.seed   = seed;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_items.size() != 0 || s_axis_tvalid || expected_randoms.size() != 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic pick_settings();
        logic [lcg_pkg::DATA_W-1:0] value;
        case ($urandom_range(7))
            0:       value = {1'b0, lcg_pkg::RESET_MODULUS};
            1:       value = $urandom_range(20, 2);
            2:       value = $urandom_range(1) | ($urandom_range(1) << 31);
            3:       value = 32'(1) << $urandom_range(30);
            default: value = $urandom;
        endcase
        write_reg(lcg_pkg::REG_MODULUS, value);
        case ($urandom_range(5))
            0:       value = '0;
            1:       value = 32'h7FFF_FFFF;
            2:       value = {1'b0, lcg_pkg::RESET_MULTIPLIER};
            default: value = $urandom;
        endcase
        write_reg(lcg_pkg::REG_MULTIPLIER, value);
        case ($urandom_range(4))
            0:       value = '0;
            1:       value = 32'h7FFF_FFFF;
            default: value = $urandom;
        endcase
        write_reg(lcg_pkg::REG_INCREMENT, value);
        if ($urandom_range(3) == 0) begin
            write_reg(lcg_pkg::REG_UNUSED, $urandom);
        end
    endtask

    task automatic push_random(input int count);
        logic [lcg_pkg::VAL_W-1:0] seed;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0:       seed = '0;
                1:       seed = '1;
                default: seed = lcg_pkg::VAL_W'($urandom);
            endcase
            push_item(($urandom_range(4) == 0) ? lcg_pkg::ACTION_LOAD : lcg_pkg::ACTION_NEXT,
                      seed);
        end
    endtask

    initial begin
        send_idle_pct = 23;
        recv_idle_pct = 58;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default minimal standard generator from the reset seed, the zero fixed point,
        // and seeds at and just below the modulus.
        push_item(lcg_pkg::ACTION_NEXT, '0);
        push_item(lcg_pkg::ACTION_NEXT, '1);
        push_item(lcg_pkg::ACTION_LOAD, '0);
        push_item(lcg_pkg::ACTION_NEXT, '1);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        push_item(lcg_pkg::ACTION_LOAD, '1);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        push_item(lcg_pkg::ACTION_LOAD, 31'd2147483646);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        wait_idle();

        // A modulus of one, then a zero modulus written with the unused top bit set.
        write_reg(lcg_pkg::REG_MODULUS, 32'd1);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        push_item(lcg_pkg::ACTION_LOAD, 31'd12345);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        wait_idle();
        write_reg(lcg_pkg::REG_MODULUS, 32'h8000_0000);
        push_item(lcg_pkg::ACTION_LOAD, 31'd7);
        push_item(lcg_pkg::ACTION_NEXT, '1);
        wait_idle();

        // Factors above their ranges with a modulus of two.
        write_reg(lcg_pkg::REG_MODULUS, 32'd2);
        write_reg(lcg_pkg::REG_MULTIPLIER, 32'hFFFF_FFFF);
        write_reg(lcg_pkg::REG_INCREMENT, 32'hFFFF_FFFF);
        push_item(lcg_pkg::ACTION_LOAD, '1);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        wait_idle();
        write_reg(lcg_pkg::REG_UNUSED, 32'hDEAD_BEEF);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        wait_idle();

        write_reg(lcg_pkg::REG_MODULUS, {1'b0, lcg_pkg::RESET_MODULUS});
        write_reg(lcg_pkg::REG_MULTIPLIER, 32'd0);
        write_reg(lcg_pkg::REG_INCREMENT, 32'd5);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        wait_idle();
        write_reg(lcg_pkg::REG_MULTIPLIER, 32'd2147483646);
        write_reg(lcg_pkg::REG_INCREMENT, 32'd2147483646);
        push_item(lcg_pkg::ACTION_LOAD, 31'd2147483646);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        push_item(lcg_pkg::ACTION_NEXT, '0);
        wait_idle();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 58 : 0;
            recv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 23 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                pick_settings();
                push_random(58);
                if (mode == 2 && seg == 1) begin
                    stall_req = stall_req + 1;
                end
                if (mode == 2 && seg == 2) begin
                    while (pending_items.size() > 29) @(posedge i_clk);
                    send_pause = 1'b1;
                    do begin
                        @(posedge i_clk);
                    end while (s_axis_tvalid || expected_randoms.size() != 0);
                    send_pause = 1'b0;
                end
                wait_idle();
            end
        end

        if (error_count == 0 && expected_randoms.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lcg_pkg.sv
hw/rtl/linear_congruential_rng.sv
tb/sv/linear_congruential_rng_test.sv
